FILE: sv/alids_pkg.sv
// Shared types, widths and command/status codes for the ordered list block.
package alids_pkg;

    // Sizing of the list.
    localparam int DEPTH = 16;
    localparam int WIDTH = 32;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ((CNT_W > 5) ? CNT_W : 5) + 1;

    // Command codes carried by cmd.
    typedef enum logic [2:0] {
        CMD_SEARCH    = 3'd0,
        CMD_INS_FRONT = 3'd1,
        CMD_INS_POS   = 3'd2,
        CMD_DEL_VAL   = 3'd3,
        CMD_DEL_FRONT = 3'd4,
        CMD_DEL_LAST  = 3'd5
    } cmd_t;

    // Result status codes.
    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_NOT_FOUND = 3'd1,
        STS_FULL      = 3'd2,
        STS_EMPTY     = 3'd3,
        STS_BAD_POS   = 3'd4
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic             match_load;
        logic             commit;
        logic             ins_en;
        logic             del_en;
        logic             del_front;
        logic [IDX_W-1:0] ins_idx;
    } cell_ctrl_t;

endpackage

FILE: sv/array_list_insert_delete_search.sv
// Top level of the ordered list: command sequencer, row of slots and result register.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one command item: cmd, value and
//   position. Output channel (out_valid/out_stall) carries one result item per
//   command: status, found_index and entry_count.
//   A new command is taken only once the last one has committed. Accepting
//   a command registers it while every slot compares its word with the value;
//   the execute state then resolves the first match along the slot chain and
//   shifts all slots at once, and the result shows once that state commits.
//   The input stalls while a command is in flight. A finished result sits in
//   the output register; when the receiver stalls it holds steady, and a
//   following command waits in its execute state until that register is free.
//   Reset (rst_n low, asynchronous) empties the list and drops any pending
//   result. Slot contents are not cleared; only filled slots are ever read.
module array_list_insert_delete_search
    import alids_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic signed [31:0] value,
    input  logic [4:0]  position,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [3:0]  found_index,
    output logic [4:0]  entry_count
);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [2:0]       cmd_reg;
    logic [WIDTH-1:0] key_reg;
    logic [4:0]       pos_reg;
    logic [2:0]       status_reg;
    logic [2:0]       status_next;
    logic [IDX_W-1:0] found_reg;
    logic [IDX_W-1:0] found_next;

    logic [WIDTH-1:0] probe;
    logic             accept;
    logic             commit;
    cell_ctrl_t       ctrl;
    logic             ins_go;
    logic             del_go;
    logic             del_front_go;
    logic [IDX_W-1:0] ins_idx;
    logic             empty;
    logic             full;
    logic             bad_pos;
    logic             any_hit;
    logic [IDX_W-1:0] hit_idx;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] fill_ext;
    logic [CMP_W-1:0] ins_ext;
    logic [IDX_W+3:0] found_ext;
    logic [CNT_W+4:0] count_ext;

    logic [WIDTH-1:0] words [DEPTH];
    logic             prior [DEPTH+1];
    logic [DEPTH-1:0] first;

    // Handshake and sequencing.
    assign probe    = WIDTH'(value);
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign commit   = (state_reg == ST_EXEC) && !(out_valid_reg && out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Row of slots with the match chain running from the front.
    assign prior[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WIDTH-1:0] prev_w;
        logic [WIDTH-1:0] next_w;

        if (i == 0)
        begin : g_head
            assign prev_w = key_reg;
        end
        else
        begin : g_body
            assign prev_w = words[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_w = words[i];
        end
        else
        begin : g_mid
            assign next_w = words[i+1];
        end

        alids_cell u_cell (
            .clk       (clk),
            .slot_idx  (IDX_W'(i)),
            .fill      (fill_reg),
            .ctrl      (ctrl),
            .probe     (probe),
            .key       (key_reg),
            .prev_word (prev_w),
            .next_word (next_w),
            .prior_in  (prior[i]),
            .prior_out (prior[i+1]),
            .first_hit (first[i]),
            .word      (words[i])
        );
    end

    // Encode the index of the single first hit.
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (first[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    assign any_hit  = prior[DEPTH];
    assign empty    = (fill_reg == '0);
    assign full     = (fill_reg >= CNT_W'(DEPTH));
    assign pos_ext  = CMP_W'(pos_reg);
    assign fill_ext = CMP_W'(fill_reg);
    assign ins_ext  = pos_ext - CMP_W'(1);
    assign bad_pos  = (pos_ext == '0) || (pos_ext > fill_ext + CMP_W'(1));

    // Command decode: status, new fill count and slot moves.
    always_comb
    begin
        status_next  = STS_OK;
        found_next   = '0;
        fill_next    = fill_reg;
        ins_go       = 1'b0;
        del_go       = 1'b0;
        del_front_go = 1'b0;
        ins_idx      = '0;
        case (cmd_reg)
            CMD_SEARCH:
            begin
                if (empty)
                begin
                    status_next = STS_EMPTY;
                end
                else if (any_hit)
                begin
                    found_next = hit_idx;
                end
                else
                begin
                    status_next = STS_NOT_FOUND;
                end
            end
            CMD_INS_FRONT:
            begin
                if (full)
                begin
                    status_next = STS_FULL;
                end
                else
                begin
                    ins_go    = 1'b1;
                    fill_next = fill_reg + CNT_W'(1);
                end
            end
            CMD_INS_POS:
            begin
                if (full)
                begin
                    status_next = STS_FULL;
                end
                else if (bad_pos)
                begin
                    status_next = STS_BAD_POS;
                end
                else
                begin
                    ins_go    = 1'b1;
                    ins_idx   = ins_ext[IDX_W-1:0];
                    fill_next = fill_reg + CNT_W'(1);
                end
            end
            CMD_DEL_VAL:
            begin
                if (empty)
                begin
                    status_next = STS_EMPTY;
                end
                else if (any_hit)
                begin
                    del_go    = 1'b1;
                    fill_next = fill_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = STS_NOT_FOUND;
                end
            end
            CMD_DEL_FRONT:
            begin
                if (empty)
                begin
                    status_next = STS_EMPTY;
                end
                else
                begin
                    del_go       = 1'b1;
                    del_front_go = 1'b1;
                    fill_next    = fill_reg - CNT_W'(1);
                end
            end
            CMD_DEL_LAST:
            begin
                if (empty)
                begin
                    status_next = STS_EMPTY;
                end
                else
                begin
                    fill_next = fill_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status_next = STS_OK;
            end
        endcase
    end

    // Broadcast control to the slots.
    assign ctrl.match_load = accept;
    assign ctrl.commit     = commit;
    assign ctrl.ins_en     = commit && ins_go;
    assign ctrl.del_en     = commit && del_go;
    assign ctrl.del_front  = del_front_go;
    assign ctrl.ins_idx    = ins_idx;

    // Output valid follows the commit and the receiver's take.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                fill_reg <= fill_next;
            end
        end
    end

    // Command and result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
            key_reg <= probe;
            pos_reg <= position;
        end
        if (commit)
        begin
            status_reg <= status_next;
            found_reg  <= found_next;
        end
    end

    // Result ports at their fixed widths.
    assign found_ext   = (IDX_W + 4)'(found_reg);
    assign count_ext   = (CNT_W + 5)'(fill_reg);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_index = found_ext[3:0];
    assign entry_count = count_ext[4:0];

endmodule

FILE: sv/alids_cell.sv
// One list slot: holds a word, compares it to the key and shifts with its neighbors.
module alids_cell
    import alids_pkg::*;
(
    input  logic             clk,
    input  logic [IDX_W-1:0] slot_idx,
    input  logic [CNT_W-1:0] fill,
    input  cell_ctrl_t       ctrl,
    input  logic [WIDTH-1:0] probe,
    input  logic [WIDTH-1:0] key,
    input  logic [WIDTH-1:0] prev_word,
    input  logic [WIDTH-1:0] next_word,
    input  logic             prior_in,
    output logic             prior_out,
    output logic             first_hit,
    output logic [WIDTH-1:0] word
);

    logic [WIDTH-1:0] word_reg;
    logic [WIDTH-1:0] word_next;
    logic             match_reg;
    logic             in_list;
    logic             hit;
    logic [IDX_W-1:0] my_idx;

    assign my_idx = slot_idx;
    assign word   = word_reg;

    // A slot only counts as a hit while it lies inside the filled part.
    assign in_list   = CNT_W'(my_idx) < fill;
    assign hit       = match_reg && in_list;
    assign first_hit = hit && !prior_in;
    assign prior_out = prior_in || hit;

    // Shift up on insert, shift down from the deleted slot onward.
    always_comb
    begin
        word_next = word_reg;
        if (ctrl.ins_en)
        begin
            if (my_idx > ctrl.ins_idx)
            begin
                word_next = prev_word;
            end
            else if (my_idx == ctrl.ins_idx)
            begin
                word_next = key;
            end
        end
        else if (ctrl.del_en && (ctrl.del_front || prior_out))
        begin
            word_next = next_word;
        end
    end

    // Payload registers: the stored word and the compare result.
    always_ff @(posedge clk)
    begin
        if (ctrl.match_load)
        begin
            match_reg <= (word_reg == probe);
        end
        if (ctrl.commit)
        begin
            word_reg <= word_next;
        end
    end

endmodule

FILE: sv/alids_checker.sv
// Port-level checker for the ordered list, bound to the top level.
module alids_checker
    import alids_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [2:0]  cmd,
    input logic signed [31:0] value,
    input logic [4:0]  position,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [3:0]  found_index,
    input logic [4:0]  entry_count
);

    // A stalled result holds still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(found_index) && $stable(entry_count))
        else $error("stalled result changed");

    // An accepted command keeps the input busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not busy after accepting a command");

    // The list never reports more entries than it holds.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(entry_count) <= 32'(DEPTH)))
        else $error("entry count above list depth");

    // Only a successful search can carry a nonzero index.
    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STS_OK) |-> (found_index == 4'd0))
        else $error("index set on a failed command");

endmodule

bind array_list_insert_delete_search alids_checker u_alids_checker (.*);
